/* rtl/apf_pkg.sv */
// Shared types and constants for the addressed packet framer.
package apf_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] START_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] END_BYTE     = 8'h00;
    localparam logic [BYTE_W-1:0] HOST_ADDRESS = 8'h00;
    localparam logic [BYTE_W-1:0] RESET_OWN_ADDRESS   = 8'd251;
    localparam logic [BYTE_W-1:0] RESET_BCAST_ADDRESS = 8'd254;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDRESS = 1'b1;

    // operation codes on the input side
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // byte slots of an outgoing packet
    localparam int TX_IDX_W = 3;
    localparam logic [TX_IDX_W-1:0] TX_SLOT_START = 3'd0;
    localparam logic [TX_IDX_W-1:0] TX_SLOT_SRC   = 3'd1;
    localparam logic [TX_IDX_W-1:0] TX_SLOT_DST   = 3'd2;
    localparam logic [TX_IDX_W-1:0] TX_SLOT_CMD   = 3'd3;
    localparam logic [TX_IDX_W-1:0] TX_SLOT_VAL   = 3'd4;
    localparam logic [TX_IDX_W-1:0] TX_SLOT_END   = 3'd5;

    // job kind doubles as the result kind code
    typedef enum logic {
        JOB_PACKET = 1'b0,
        JOB_SEND   = 1'b1
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [BYTE_W-1:0] src;
        logic [BYTE_W-1:0] dst;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] val;
    } t_job;

    typedef enum logic [5:0] {
        POS_IDLE = 6'b000001,
        POS_SRC  = 6'b000010,
        POS_DST  = 6'b000100,
        POS_CMD  = 6'b001000,
        POS_PAY  = 6'b010000,
        POS_END  = 6'b100000
    } t_frame_pos;

endpackage

/* rtl/apf_front.sv */
// Front end: receive framing state machine and classification of items into jobs.
module apf_front
    import apf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_operation,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_line_error,
    input  logic [BYTE_W-1:0] i_send_command,
    input  logic [BYTE_W-1:0] i_send_value,
    input  logic [BYTE_W-1:0] i_own_address,
    input  logic [BYTE_W-1:0] i_bcast_address,
    output logic              o_job_push,
    output t_job              o_job
);

    t_frame_pos        r_pos, n_pos;
    logic [BYTE_W-1:0] r_src, r_dst, r_cmd, r_pay;
    logic              rx_data;
    logic              dst_match;

    // a receive byte that advances the frame (no error, not a start byte)
    assign rx_data   = i_accept && (i_operation == OP_RX) && !i_line_error
                       && (i_rx_byte != START_BYTE);
    assign dst_match = (r_dst == i_bcast_address) || (r_dst == i_own_address);

    always_comb begin
        n_pos      = r_pos;
        o_job_push = 1'b0;
        o_job      = '{kind: JOB_PACKET, src: r_src, dst: r_dst, cmd: r_cmd, val: r_pay};
        if (i_accept) begin
            if (i_operation == OP_SEND) begin
                o_job = '{kind: JOB_SEND, src: i_own_address, dst: HOST_ADDRESS,
                          cmd: i_send_command, val: i_send_value};
                o_job_push = (i_send_command != START_BYTE) && (i_send_value != START_BYTE);
            end else if (i_line_error) begin
                n_pos = POS_IDLE;
            end else if (i_rx_byte == START_BYTE) begin
                n_pos = POS_SRC;
            end else begin
                unique case (r_pos)
                    POS_SRC: n_pos = POS_DST;
                    POS_DST: n_pos = POS_CMD;
                    POS_CMD: n_pos = POS_PAY;
                    POS_PAY: n_pos = POS_END;
                    POS_END: begin
                        n_pos      = POS_IDLE;
                        o_job_push = (i_rx_byte == END_BYTE) && dst_match;
                    end
                    default: n_pos = POS_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_data) begin
            unique case (r_pos)
                POS_SRC: r_src <= i_rx_byte;
                POS_DST: r_dst <= i_rx_byte;
                POS_CMD: r_cmd <= i_rx_byte;
                POS_PAY: r_pay <= i_rx_byte;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/apf_queue.sv */
// Short job queue between the front end and the back end.
module apf_queue
    import apf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT  = (AW + 1)'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW:0]   r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* rtl/apf_back.sv */
// Back end: expands jobs into result transfers held in the output register.
module apf_back
    import apf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_q_job,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_result_kind,
    output logic [BYTE_W-1:0] o_tx_byte,
    output logic [BYTE_W-1:0] o_src_address,
    output logic [BYTE_W-1:0] o_dst_address,
    output logic [BYTE_W-1:0] o_command,
    output logic [BYTE_W-1:0] o_payload,
    output logic              o_last
);

    t_job                r_job;
    logic                r_job_valid;
    logic [TX_IDX_W-1:0] r_idx;
    logic                r_out_valid;
    logic                r_kind;
    logic [BYTE_W-1:0]   r_tx, r_src, r_dst, r_cmd, r_pay;
    logic                r_last;
    logic                out_free, emit, job_done, is_packet;
    logic [BYTE_W-1:0]   tx_sel;

    assign is_packet = (r_job.kind == JOB_PACKET);
    assign out_free  = !r_out_valid || i_pop;
    assign emit      = r_job_valid && out_free;
    assign job_done  = emit && (is_packet || (r_idx == TX_SLOT_END));
    assign o_q_pop   = !i_q_empty && (!r_job_valid || job_done);

    always_comb begin
        unique case (r_idx)
            TX_SLOT_START: tx_sel = START_BYTE;
            TX_SLOT_SRC:   tx_sel = r_job.src;
            TX_SLOT_DST:   tx_sel = r_job.dst;
            TX_SLOT_CMD:   tx_sel = r_job.cmd;
            TX_SLOT_VAL:   tx_sel = r_job.val;
            TX_SLOT_END:   tx_sel = END_BYTE;
            default:       tx_sel = END_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_job_valid <= 1'b1;
                r_idx       <= TX_SLOT_START;
            end else if (job_done) begin
                r_job_valid <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_kind <= r_job.kind;
            r_last <= job_done;
            if (is_packet) begin
                r_tx  <= '0;
                r_src <= r_job.src;
                r_dst <= r_job.dst;
                r_cmd <= r_job.cmd;
                r_pay <= r_job.val;
            end else begin
                r_tx  <= tx_sel;
                r_src <= '0;
                r_dst <= '0;
                r_cmd <= '0;
                r_pay <= '0;
            end
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_result_kind = r_kind;
    assign o_tx_byte     = r_tx;
    assign o_src_address = r_src;
    assign o_dst_address = r_dst;
    assign o_command     = r_cmd;
    assign o_payload     = r_pay;
    assign o_last        = r_last;

endmodule

/* rtl/addressed_packet_framer.sv */
// Addressed packet framer top level: config registers, front end, job queue, back end.
// An accepted item's job is held in the job queue, the back end's job register and the
// output register in turn. Throughput: one input item per cycle while the job queue
// has room; results leave one per cycle while popped; a send item yields six results.
// Reset (synchronous, active low) empties queue and output register, idles the framer
// and loads own address 251 and broadcast address 254; held packet bytes are not reset.
module addressed_packet_framer
    import apf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_operation,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_line_error,
    input  logic [BYTE_W-1:0]    i_send_command,
    input  logic [BYTE_W-1:0]    i_send_value,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_result_kind,
    output logic [BYTE_W-1:0]    o_tx_byte,
    output logic [BYTE_W-1:0]    o_src_address,
    output logic [BYTE_W-1:0]    o_dst_address,
    output logic [BYTE_W-1:0]    o_command,
    output logic [BYTE_W-1:0]    o_payload,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic [BYTE_W-1:0] r_own_address, r_bcast_address;
    logic              accept;
    logic              job_push, q_full, q_empty, q_pop;
    t_job              front_job, q_job;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address   <= RESET_OWN_ADDRESS;
            r_bcast_address <= RESET_BCAST_ADDRESS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OWN_ADDRESS:   r_own_address   <= i_cfg_data;
                CFG_BCAST_ADDRESS: r_bcast_address <= i_cfg_data;
                default: ;
            endcase
        end
    end

    apf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_operation     (i_operation),
        .i_rx_byte       (i_rx_byte),
        .i_line_error    (i_line_error),
        .i_send_command  (i_send_command),
        .i_send_value    (i_send_value),
        .i_own_address   (r_own_address),
        .i_bcast_address (r_bcast_address),
        .o_job_push      (job_push),
        .o_job           (front_job)
    );

    apf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    apf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_job       (q_job),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result_kind (o_result_kind),
        .o_tx_byte     (o_tx_byte),
        .o_src_address (o_src_address),
        .o_dst_address (o_dst_address),
        .o_command     (o_command),
        .o_payload     (o_payload),
        .o_last        (o_last)
    );

endmodule
